// ===== hdl/sme_pkg.sv =====
// shared types and constants for the stable matching engine
// used by sme_ctrl, sme_datapath and stable_matching_engine_core
// no dependencies
package sme_pkg;

  // default party count and fixed payload field widths
  localparam int DEFAULT_PARTIES = 8;
  localparam int MODE_W          = 2;
  localparam int FIELD_W         = 3;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD_PROP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_ACC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START     = 2'd2;

  // controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_POP    = 6'b000010,
    ST_PREF   = 6'b000100,
    ST_RANK_A = 6'b001000,
    ST_RANK_B = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  // commands from controller to datapath, at most one per cycle
  typedef struct packed {
    logic start;
    logic load_prop;
    logic load_acc;
    logic pop;
    logic pref;
    logic rank_a;
    logic rank_b;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic stack_empty;
    logic choice_done;
    logic acc_bad;
    logic acc_taken;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/stable_matching_engine_core.sv =====
// top level of the stable matching engine: controller plus datapath
// depends on sme_pkg, sme_ctrl and sme_datapath
//
// usage:
//   input channel in_valid/in_ready carries mode, row, position, choice.
//   mode 0 writes proposer row's list entry at position, mode 1 writes
//   acceptor row's list entry (stored as a rank), mode 2 starts a run.
//   loads with any field not below PARTIES, and mode 3, are dropped.
//   loads stream back to back. a start enters the pop state, then each
//   proposal passes the pop and preference read states, plus two rank
//   reads from the single rank memory port when the acceptor is already
//   taken; popping an exhausted proposer uses the pop state alone. at most
//   PARTIES*PARTIES proposals occur, then one result per proposer, in
//   proposer order, one per cycle unless stalled, last one flagged.
//   in_ready is low from the start transfer until the last result is loaded.
//   result channel out_valid/out_ready holds a result in its register while
//   the receiver stalls; emission pauses until the transfer completes.
//   reset clears the controller, free stack count and result valid;
//   preference memories keep their contents only once written and are not cleared.
module stable_matching_engine_core #(
  parameter int PARTIES = sme_pkg::DEFAULT_PARTIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sme_pkg::MODE_W-1:0]    in_mode,
  input  logic [sme_pkg::FIELD_W-1:0]   in_row,
  input  logic [sme_pkg::FIELD_W-1:0]   in_position,
  input  logic [sme_pkg::FIELD_W-1:0]   in_choice,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sme_pkg::FIELD_W-1:0]   out_proposer,
  output logic [sme_pkg::FIELD_W-1:0]   out_partner,
  output logic                          out_matched,
  output logic                          out_last
);

  sme_pkg::cmd_t    cmd;
  sme_pkg::status_t sts;

  // control
  sme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sme_datapath #(
    .PARTIES (PARTIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_row       (in_row),
    .in_position  (in_position),
    .in_choice    (in_choice),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_proposer (out_proposer),
    .out_partner  (out_partner),
    .out_matched  (out_matched),
    .out_last     (out_last)
  );

  // at most one datapath action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // a start transfer closes intake
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == sme_pkg::MODE_START)) |=> !in_ready)
    else $error("intake open right after start");

  // emitting the last result reopens intake
  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> (in_ready && out_valid && out_last))
    else $error("last result did not end the run");

  // results are only produced while intake is closed
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_ready)
    else $error("result emitted while idle");

endmodule

// ===== hdl/sme_ctrl.sv =====
// controller state machine for the stable matching engine
// sequences loads, proposals, rank compares and result emission
// depends on sme_pkg
module sme_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [sme_pkg::MODE_W-1:0]    in_mode,
  output logic                          in_ready,
  input  sme_pkg::status_t              sts,
  output sme_pkg::cmd_t                 cmd
);

  sme_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sme_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == sme_pkg::ST_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      sme_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            sme_pkg::MODE_LOAD_PROP: cmd.load_prop = 1'b1;
            sme_pkg::MODE_LOAD_ACC:  cmd.load_acc  = 1'b1;
            sme_pkg::MODE_START: begin
              cmd.start = 1'b1;
              state_nxt = sme_pkg::ST_POP;
            end
            default: ;
          endcase
        end
      end
      sme_pkg::ST_POP: begin
        if (sts.stack_empty) begin
          state_nxt = sme_pkg::ST_EMIT;
        end else begin
          cmd.pop = 1'b1;
          if (!sts.choice_done) state_nxt = sme_pkg::ST_PREF;
        end
      end
      sme_pkg::ST_PREF: begin
        cmd.pref = 1'b1;
        if (!sts.acc_bad && sts.acc_taken) state_nxt = sme_pkg::ST_RANK_A;
        else state_nxt = sme_pkg::ST_POP;
      end
      sme_pkg::ST_RANK_A: begin
        cmd.rank_a = 1'b1;
        state_nxt  = sme_pkg::ST_RANK_B;
      end
      sme_pkg::ST_RANK_B: begin
        cmd.rank_b = 1'b1;
        state_nxt  = sme_pkg::ST_POP;
      end
      sme_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = sme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sme_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/sme_datapath.sv =====
// datapath of the stable matching engine: preference and rank memories,
// free stack, matching tables and the result register
// depends on sme_pkg
module sme_datapath #(
  parameter int PARTIES = sme_pkg::DEFAULT_PARTIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sme_pkg::cmd_t                 cmd,
  output sme_pkg::status_t              sts,
  input  logic [sme_pkg::FIELD_W-1:0]   in_row,
  input  logic [sme_pkg::FIELD_W-1:0]   in_position,
  input  logic [sme_pkg::FIELD_W-1:0]   in_choice,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sme_pkg::FIELD_W-1:0]   out_proposer,
  output logic [sme_pkg::FIELD_W-1:0]   out_partner,
  output logic                          out_matched,
  output logic                          out_last
);

  localparam int IDX_W  = (PARTIES > 2) ? $clog2(PARTIES) : 1;
  localparam int CNT_W  = $clog2(PARTIES + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PARTIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARTIES - 1);

  // preference memories, addressed {row, column}
  logic [IDX_W-1:0] pref_mem [DEPTH];
  logic [IDX_W-1:0] rank_mem [DEPTH];
  logic [IDX_W-1:0] pref_q_r, rank_q_r;
  logic [ADDR_W-1:0] pref_raddr, rank_raddr;

  // matching state
  logic [IDX_W-1:0] stack_r   [PARTIES];
  logic [CNT_W-1:0] nc_r      [PARTIES];
  logic [IDX_W-1:0] apart_r   [PARTIES];
  logic             taken_r   [PARTIES];
  logic [IDX_W-1:0] ppart_r   [PARTIES];
  logic             pmatch_r  [PARTIES];
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] p_r, a_r, cur_r, rp_r, emit_idx_r;

  // result register
  logic                        out_valid_r;
  logic [sme_pkg::FIELD_W-1:0] out_proposer_r, out_partner_r;
  logic                        out_matched_r, out_last_r;

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] p_top;
  logic [IDX_W-1:0] row_i, pos_i, choice_i;
  logic             load_ok;
  logic             push_en;
  logic [IDX_W-1:0] push_val;
  logic             keep_new;

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign p_top  = stack_r[cnt_m1[IDX_W-1:0]];

  assign row_i    = IDX_W'(in_row);
  assign pos_i    = IDX_W'(in_position);
  assign choice_i = IDX_W'(in_choice);
  assign load_ok  = (int'(in_row) < PARTIES) && (int'(in_position) < PARTIES)
                 && (int'(in_choice) < PARTIES);

  // status toward the controller
  assign sts.stack_empty = (cnt_r == '0);
  assign sts.choice_done = (nc_r[p_top] >= CNT_FULL);
  assign sts.acc_bad     = (int'(pref_q_r) >= PARTIES);
  assign sts.acc_taken   = taken_r[pref_q_r];
  assign sts.emit_last   = (emit_idx_r == IDX_LAST);
  assign sts.out_free    = !out_valid_r || out_ready;

  // memory read addresses
  assign pref_raddr = {p_top, nc_r[p_top][IDX_W-1:0]};
  assign rank_raddr = cmd.rank_a ? {a_r, cur_r} : {pref_q_r, p_r};

  // preference memory: write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_prop && load_ok) pref_mem[{row_i, pos_i}] <= choice_i;
    pref_q_r <= pref_mem[pref_raddr];
  end

  // rank memory: acceptor list stored as rank per proposer
  always_ff @(posedge clk) begin
    if (cmd.load_acc && load_ok) rank_mem[{row_i, choice_i}] <= pos_i;
    rank_q_r <= rank_mem[rank_raddr];
  end

  // push decision after an evaluation step
  assign keep_new = (rp_r < rank_q_r);
  always_comb begin
    push_en  = 1'b0;
    push_val = p_r;
    if (cmd.pref && sts.acc_bad) begin
      push_en = 1'b1;
    end else if (cmd.rank_b) begin
      push_en  = 1'b1;
      push_val = keep_new ? cur_r : p_r;
    end
  end

  // free stack count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= CNT_FULL;
    end else if (cmd.pop) begin
      cnt_r <= cnt_m1;
    end else if (push_en && (cnt_r < CNT_FULL)) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // free stack, pointers and matching tables
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < PARTIES; i++) begin
        stack_r[i]  <= IDX_W'(i);
        nc_r[i]     <= '0;
        taken_r[i]  <= 1'b0;
        pmatch_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.pop) begin
        p_r <= p_top;
        if (!sts.choice_done) nc_r[p_top] <= nc_r[p_top] + CNT_W'(1);
      end
      if (push_en && (cnt_r < CNT_FULL)) stack_r[cnt_r[IDX_W-1:0]] <= push_val;
      // first proposal to a free acceptor is kept
      if (cmd.pref) begin
        a_r   <= pref_q_r;
        cur_r <= apart_r[pref_q_r];
        if (!sts.acc_bad && !sts.acc_taken) begin
          taken_r[pref_q_r] <= 1'b1;
          apart_r[pref_q_r] <= p_r;
          pmatch_r[p_r]     <= 1'b1;
          ppart_r[p_r]      <= pref_q_r;
        end
      end
      if (cmd.rank_a) rp_r <= rank_q_r;
      // strictly better proposer replaces the current partner
      if (cmd.rank_b && keep_new) begin
        apart_r[a_r]    <= p_r;
        pmatch_r[cur_r] <= 1'b0;
        pmatch_r[p_r]   <= 1'b1;
        ppart_r[p_r]    <= a_r;
      end
    end
  end

  // result emission counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      emit_idx_r <= '0;
    end else if (cmd.emit) begin
      emit_idx_r <= emit_idx_r + IDX_W'(1);
    end
  end

  // result register and its valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_proposer_r <= sme_pkg::FIELD_W'(emit_idx_r);
      out_partner_r  <= pmatch_r[emit_idx_r]
                        ? sme_pkg::FIELD_W'(ppart_r[emit_idx_r]) : '0;
      out_matched_r  <= pmatch_r[emit_idx_r];
      out_last_r     <= (emit_idx_r == IDX_LAST);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_proposer = out_proposer_r;
  assign out_partner  = out_partner_r;
  assign out_matched  = out_matched_r;
  assign out_last     = out_last_r;

endmodule

// ===== sim/stable_matching_engine_core_test.sv =====
// testbench for stable_matching_engine_core: table loads, matching runs, random traffic
// depends on sme_pkg and the stable_matching_engine_core rtl
// a built-in gale-shapley predictor checks each pairing result in order
module stable_matching_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARTIES = sme_pkg::DEFAULT_PARTIES;
  localparam int MODE_W = sme_pkg::MODE_W;
  localparam int FIELD_W = sme_pkg::FIELD_W;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 110;

  typedef logic [FIELD_W-1:0] choice_list_t [PARTIES];

  typedef struct {
    logic [FIELD_W-1:0] proposer;
    logic [FIELD_W-1:0] partner;
    logic               matched;
    logic               last;
  } pairing_t;

  // shadow tables, matching predictor and queue of expected pairings
  class pairing_book_t;
    logic [FIELD_W-1:0] prefs [PARTIES][PARTIES];
    logic [FIELD_W-1:0] ranks [PARTIES][PARTIES];
    pairing_t pending_pairs [$];
    int unsigned mismatches = 0;

    // proposer-optimal matching over the shadow tables
    function void run_pairing();
      int unsigned next_pos [PARTIES];
      int unsigned holder [PARTIES];
      bit held [PARTIES];
      int unsigned free_list [PARTIES];
      int unsigned free_top;
      int unsigned i, p, a, cur;
      pairing_t r;
      for (i = 0; i < PARTIES; i++) begin
        next_pos[i] = 0;
        holder[i] = 0;
        held[i] = 1'b0;
        free_list[i] = i;
      end
      free_top = PARTIES;
      while (free_top > 0) begin
        free_top--;
        p = free_list[free_top];
        if (next_pos[p] >= PARTIES) continue;
        a = prefs[p][next_pos[p]];
        next_pos[p]++;
        if (!held[a]) begin
          held[a] = 1'b1;
          holder[a] = p;
        end else begin
          cur = holder[a];
          // strictly better rank wins, the current partner keeps a tie
          if (ranks[a][p] < ranks[a][cur]) begin
            holder[a] = p;
            p = cur;
          end
          if (free_top < PARTIES) begin
            free_list[free_top] = p;
            free_top++;
          end
        end
      end
      // one pairing per proposer, lowest acceptor first
      for (p = 0; p < PARTIES; p++) begin
        r.proposer = FIELD_W'(p);
        r.partner = '0;
        r.matched = 1'b0;
        r.last = (p == PARTIES - 1);
        for (a = 0; a < PARTIES; a++) begin
          if (held[a] && holder[a] == p && !r.matched) begin
            r.partner = FIELD_W'(a);
            r.matched = 1'b1;
          end
        end
        pending_pairs = {pending_pairs, r};
      end
    endfunction

    // note an accepted input transfer
    function void take_item(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] row,
                            logic [FIELD_W-1:0] pos, logic [FIELD_W-1:0] choice);
      case (mode)
        sme_pkg::MODE_LOAD_PROP: prefs[row][pos] = choice;
        sme_pkg::MODE_LOAD_ACC:  ranks[row][choice] = pos;
        sme_pkg::MODE_START:     run_pairing();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned expected,
                                logic [FIELD_W-1:0] actual);
      if (actual !== expected[FIELD_W-1:0]) begin
        $error("%s: expected %0d, got %0d", name, expected, actual);
        mismatches++;
      end
    endfunction

    // check a result transfer against the oldest expectation
    function void check_pair(pairing_t got);
      pairing_t want;
      if (pending_pairs.size() == 0) begin
        $error("proposer: expected no result, got %0d", got.proposer);
        mismatches++;
        return;
      end
      want = pending_pairs.pop_front();
      compare_field("proposer", want.proposer, got.proposer);
      compare_field("partner", want.partner, got.partner);
      compare_field("matched", want.matched, {2'b00, got.matched});
      compare_field("last", want.last, {2'b00, got.last});
    endfunction

    function int unsigned pending_count();
      return pending_pairs.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  in_mode = '0;
  logic [FIELD_W-1:0] in_row = '0;
  logic [FIELD_W-1:0] in_position = '0;
  logic [FIELD_W-1:0] in_choice = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] out_proposer;
  logic [FIELD_W-1:0] out_partner;
  logic               out_matched;
  logic               out_last;

  logic calm = 1'b0;
  int unsigned items_sent = 0;
  pairing_book_t book;

  stable_matching_engine_core #(.PARTIES(PARTIES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_row(in_row), .in_position(in_position), .in_choice(in_choice),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_proposer(out_proposer), .out_partner(out_partner),
    .out_matched(out_matched), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // receiver stalls at random unless in a calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 23);
  end

  // result transfer monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      book.check_pair('{out_proposer, out_partner, out_matched, out_last});
    end
  end

  // watchdog: too long with no transfer on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // random field value
  function automatic logic [FIELD_W-1:0] rnd_field();
    return FIELD_W'($urandom);
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] row,
                           logic [FIELD_W-1:0] pos, logic [FIELD_W-1:0] choice);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_row <= row;
    in_position <= pos;
    in_choice <= choice;
    do @(posedge clk); while (in_ready !== 1'b1);
    book.take_item(mode, row, pos, choice);
    if (mode != MODE_NONE) items_sent++;
  endtask

  // permutation, or free draws below span that may repeat
  function automatic void fill_list(output choice_list_t lst, input bit shuffle,
                                    input int unsigned span);
    int unsigned i, j;
    logic [FIELD_W-1:0] t;
    for (i = 0; i < PARTIES; i++) begin
      lst[i] = shuffle ? FIELD_W'(i) : FIELD_W'($urandom_range(span - 1));
    end
    if (shuffle) begin
      for (i = PARTIES - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = lst[i];
        lst[i] = lst[j];
        lst[j] = t;
      end
    end
  endfunction

  task automatic load_list(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] row,
                           choice_list_t lst);
    int unsigned pos;
    for (pos = 0; pos < PARTIES; pos++) send_item(mode, row, FIELD_W'(pos), lst[pos]);
  endtask

  initial begin
    choice_list_t lst;
    int unsigned r, n, kind, span, base;
    bit first;
    book = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both tables so that no run reads an unwritten entry
    for (r = 0; r < PARTIES; r++) begin
      fill_list(lst, 1'b1, PARTIES);
      load_list(sme_pkg::MODE_LOAD_PROP, FIELD_W'(r), lst);
    end
    for (r = 0; r < PARTIES; r++) begin
      fill_list(lst, 1'b1, PARTIES);
      load_list(sme_pkg::MODE_LOAD_ACC, FIELD_W'(r), lst);
    end

    // directed: baseline run, unused mode, field extremes
    send_item(sme_pkg::MODE_START, 0, 0, 0);
    send_item(MODE_NONE, 7, 7, 7);
    send_item(MODE_NONE, 0, 0, 0);
    send_item(sme_pkg::MODE_LOAD_PROP, 7, 7, 0);
    send_item(sme_pkg::MODE_LOAD_PROP, 0, 0, 7);
    send_item(sme_pkg::MODE_LOAD_ACC, 7, 0, 7);
    send_item(sme_pkg::MODE_LOAD_ACC, 0, 7, 0);
    // same proposer named twice in one acceptor list
    send_item(sme_pkg::MODE_LOAD_ACC, 2, 0, 5);
    send_item(sme_pkg::MODE_LOAD_ACC, 2, 6, 5);
    // two proposers ranked equal by acceptor 1, both want it first
    send_item(sme_pkg::MODE_LOAD_ACC, 1, 0, 3);
    send_item(sme_pkg::MODE_LOAD_ACC, 1, 0, 4);
    send_item(sme_pkg::MODE_LOAD_PROP, 3, 0, 1);
    send_item(sme_pkg::MODE_LOAD_PROP, 4, 0, 1);
    send_item(sme_pkg::MODE_START, 0, 0, 0);
    // back to back runs
    send_item(sme_pkg::MODE_START, 7, 7, 7);
    send_item(sme_pkg::MODE_START, 0, 0, 0);

    // random sequences, the first one crowds proposers onto few acceptors
    base = items_sent;
    first = 1'b1;
    while (items_sent - base < RANDOM_ITEMS) begin
      n = items_sent - base;
      calm <= (n >= 30 && n < 80);
      kind = first ? 60 : $urandom_range(99);
      first = 1'b0;
      if (kind < 40) begin
        // rewrite a few proposer lists, then run
        repeat ($urandom_range(1, 3)) begin
          fill_list(lst, 1'($urandom_range(1)), PARTIES);
          load_list(sme_pkg::MODE_LOAD_PROP, FIELD_W'($urandom_range(PARTIES - 1)), lst);
        end
        send_item(sme_pkg::MODE_START, rnd_field(), rnd_field(), rnd_field());
      end else if (kind < 60) begin
        // rewrite acceptor lists, repeats leave ties behind
        repeat ($urandom_range(1, 2)) begin
          fill_list(lst, 1'($urandom_range(1)), PARTIES);
          load_list(sme_pkg::MODE_LOAD_ACC, FIELD_W'($urandom_range(PARTIES - 1)), lst);
        end
        send_item(sme_pkg::MODE_START, rnd_field(), rnd_field(), rnd_field());
      end else if (kind < 68) begin
        // every proposer limited to a few acceptors, lists run out
        span = $urandom_range(1, 3);
        for (r = 0; r < PARTIES; r++) begin
          fill_list(lst, 1'b0, span);
          load_list(sme_pkg::MODE_LOAD_PROP, FIELD_W'(r), lst);
        end
        send_item(sme_pkg::MODE_START, rnd_field(), rnd_field(), rnd_field());
      end else if (kind < 82) begin
        // scattered single entries, then run
        repeat ($urandom_range(1, 6)) begin
          send_item($urandom_range(1) ? sme_pkg::MODE_LOAD_ACC : sme_pkg::MODE_LOAD_PROP,
                    rnd_field(), rnd_field(), rnd_field());
        end
        send_item(sme_pkg::MODE_START, rnd_field(), rnd_field(), rnd_field());
      end else if (kind < 92) begin
        // noise: unused mode and loads with no run after them
        repeat ($urandom_range(1, 3)) begin
          send_item(MODE_NONE, rnd_field(), rnd_field(), rnd_field());
        end
        repeat ($urandom_range(0, 3)) begin
          send_item($urandom_range(1) ? sme_pkg::MODE_LOAD_ACC : sme_pkg::MODE_LOAD_PROP,
                    rnd_field(), rnd_field(), rnd_field());
        end
      end else begin
        send_item(sme_pkg::MODE_START, rnd_field(), rnd_field(), rnd_field());
        send_item(sme_pkg::MODE_START, rnd_field(), rnd_field(), rnd_field());
      end
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    // drain the remaining pairings, then allow a few quiet cycles
    while (book.pending_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
